// ===== src/mpeg_pkg.sv =====
// Shared types and constants for the multichannel PWM event generator.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package mpeg_pkg;

   // Field widths fixed by the request and response formats.
   localparam int REQ_W        = 2;
   localparam int CH_FIELD_W   = 3;
   localparam int RATE_W       = 8;
   localparam int MASK_W       = 8;
   localparam int MAX_CHANNELS = 8;

   // Defaults for the top-level parameters.
   localparam int NUM_CHANNELS_DEF = 8;
   localparam int PERIOD_TICKS_DEF = 256;

   typedef enum logic [REQ_W-1:0] {
      REQ_TICK   = 2'd0,
      REQ_ALLOC  = 2'd1,
      REQ_RECONF = 2'd2,
      REQ_CANCEL = 2'd3
   } mpeg_req_code_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } mpeg_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic execute;
   } mpeg_cmd_type;

endpackage

`default_nettype wire

// ===== src/multichannel_pwm_event_generator.sv =====
// Top level of the multichannel PWM event generator.
// Instantiates mpeg_ctrl and mpeg_datapath; depends on mpeg_pkg.
`default_nettype none

// A shared PWM phase counter serves a table of up to eight channels. Each
// request beat is a tick, an allocate, a reconfigure or a cancel, and each
// produces exactly one response beat. A request is taken at the rising edge
// where start is high and busy is low; busy is then high for one cycle while
// the request executes, and the response appears on the rsp_ ports for
// exactly one cycle, marked by rsp_valid, in the cycle after that. The
// receiver cannot hold a response off, so it must take every beat in the
// cycle it is shown. A new request may be presented in that same cycle, but
// none is taken while busy is high: the controller runs its capture and
// execute steps for one request at a time, all channels being compared in
// parallel within the execute cycle. No clearing pass runs after reset.
// Allocate grants the lowest free channel and starts it low; cancel always
// succeeds and freezes the channel's level and compare value; on a tick a
// channel whose compare value equals the new count goes high, and otherwise
// the wrap of the count to zero brings it low.

module multichannel_pwm_event_generator #(
   parameter int NUM_CHANNELS = mpeg_pkg::NUM_CHANNELS_DEF,
   parameter int PERIOD_TICKS = mpeg_pkg::PERIOD_TICKS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [mpeg_pkg::REQ_W-1:0]      req_type,
   input  logic [mpeg_pkg::CH_FIELD_W-1:0] req_channel,
   input  logic [mpeg_pkg::RATE_W-1:0]     req_rate,
   output logic                            rsp_valid,
   output logic                            rsp_status,
   output logic [mpeg_pkg::CH_FIELD_W-1:0] rsp_channel_out,
   output logic [mpeg_pkg::MASK_W-1:0]     rsp_high_events,
   output logic [mpeg_pkg::MASK_W-1:0]     rsp_low_events,
   output logic [mpeg_pkg::MASK_W-1:0]     rsp_levels
);
   import mpeg_pkg::*;

   // Commands from the controller to the datapath.
   mpeg_cmd_type cmd;

   mpeg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .cmd       (cmd),
      .rsp_valid (rsp_valid)
   );

   mpeg_datapath #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .PERIOD_TICKS (PERIOD_TICKS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_type        (req_type),
      .req_channel     (req_channel),
      .req_rate        (req_rate),
      .rsp_status      (rsp_status),
      .rsp_channel_out (rsp_channel_out),
      .rsp_high_events (rsp_high_events),
      .rsp_low_events  (rsp_low_events),
      .rsp_levels      (rsp_levels)
   );

endmodule

`default_nettype wire

// ===== src/mpeg_ctrl.sv =====
// Controller for the multichannel PWM event generator: accept/execute sequencing.
// Depends on mpeg_pkg for the state type and the command struct.
`default_nettype none

module mpeg_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   output mpeg_pkg::mpeg_cmd_type cmd,
   output logic                  rsp_valid
);
   import mpeg_pkg::*;

   mpeg_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      busy        = 1'b0;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            busy        = 1'b1;
            cmd.execute = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.execute;
   end

   assign rsp_valid = rsp_valid_ff;

   // An accepted beat always makes the block busy for its execute cycle.
   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not enter the execute cycle");

   // Execution is followed in the next cycle by the response strobe, with busy low again.
   a_exec_rsp : assert property (@(posedge clock) disable iff (reset)
      cmd.execute |=> (rsp_valid && !busy))
      else $error("execute cycle not followed by a response strobe");

   // Every response strobe traces back to a request captured before its execute cycle.
   a_rsp_origin : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(cmd.capture, 2))
      else $error("response strobe without a captured request");

   a_busy_single : assert property (@(posedge clock) disable iff (reset)
      busy |=> !busy)
      else $error("busy held for more than one cycle");

endmodule

`default_nettype wire

// ===== src/mpeg_datapath.sv =====
// Datapath for the multichannel PWM event generator: phase counter, channel
// table and response registers. Depends on mpeg_pkg.
`default_nettype none

module mpeg_datapath #(
   parameter int NUM_CHANNELS = mpeg_pkg::NUM_CHANNELS_DEF,
   parameter int PERIOD_TICKS = mpeg_pkg::PERIOD_TICKS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  mpeg_pkg::mpeg_cmd_type          cmd,
   input  logic [mpeg_pkg::REQ_W-1:0]      req_type,
   input  logic [mpeg_pkg::CH_FIELD_W-1:0] req_channel,
   input  logic [mpeg_pkg::RATE_W-1:0]     req_rate,
   output logic                            rsp_status,
   output logic [mpeg_pkg::CH_FIELD_W-1:0] rsp_channel_out,
   output logic [mpeg_pkg::MASK_W-1:0]     rsp_high_events,
   output logic [mpeg_pkg::MASK_W-1:0]     rsp_low_events,
   output logic [mpeg_pkg::MASK_W-1:0]     rsp_levels
);
   import mpeg_pkg::*;

   localparam int CH_LIMIT = (NUM_CHANNELS < MAX_CHANNELS) ? NUM_CHANNELS : MAX_CHANNELS;
   localparam int PHASE_W  = $clog2(PERIOD_TICKS);
   localparam int CMP_W    = (PHASE_W > RATE_W) ? PHASE_W : RATE_W;
   localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(PERIOD_TICKS - 1);

   // Captured request.
   logic [REQ_W-1:0]      req_type_ff;
   logic [CH_FIELD_W-1:0] req_channel_ff;
   logic [RATE_W-1:0]     req_rate_ff;

   // Channel table and shared phase counter.
   logic [PHASE_W-1:0]  phase_ff, phase_in;
   logic [CH_LIMIT-1:0] enabled_ff, enabled_in;
   logic [CH_LIMIT-1:0] level_ff, level_in;
   logic [RATE_W-1:0]   compare_ff [CH_LIMIT];
   logic [RATE_W-1:0]   compare_in [CH_LIMIT];

   // Response registers.
   logic                  status_ff, status_in;
   logic [CH_FIELD_W-1:0] chan_out_ff, chan_out_in;
   logic [MASK_W-1:0]     high_ff, high_in;
   logic [MASK_W-1:0]     low_ff, low_in;
   logic [MASK_W-1:0]     levels_ff, levels_in;

   logic [PHASE_W-1:0]    phase_step;
   logic [CMP_W-1:0]      phase_wide;
   logic                  found;
   logic [CH_FIELD_W-1:0] grant;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_type_ff    <= req_type;
         req_channel_ff <= req_channel;
         req_rate_ff    <= req_rate;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= '0;
         enabled_ff <= '0;
         level_ff   <= '0;
         for (int i = 0; i < CH_LIMIT; i++) begin
            compare_ff[i] <= '0;
         end
      end else if (cmd.execute) begin
         phase_ff   <= phase_in;
         enabled_ff <= enabled_in;
         level_ff   <= level_in;
         for (int i = 0; i < CH_LIMIT; i++) begin
            compare_ff[i] <= compare_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         status_ff   <= status_in;
         chan_out_ff <= chan_out_in;
         high_ff     <= high_in;
         low_ff      <= low_in;
         levels_ff   <= levels_in;
      end
   end

   // Lowest free channel for allocation.
   always_comb begin
      found = 1'b0;
      grant = '0;
      for (int i = CH_LIMIT - 1; i >= 0; i--) begin
         if (!enabled_ff[i]) begin
            found = 1'b1;
            grant = CH_FIELD_W'(i);
         end
      end
   end

   always_comb begin
      phase_step = (phase_ff == PHASE_LAST) ? '0 : phase_ff + PHASE_W'(1);
      phase_wide = CMP_W'(phase_step);
      phase_in    = phase_ff;
      enabled_in  = enabled_ff;
      level_in    = level_ff;
      compare_in  = compare_ff;
      status_in   = 1'b0;
      chan_out_in = '0;
      high_in     = '0;
      low_in      = '0;
      case (mpeg_req_code_type'(req_type_ff))
         REQ_TICK: begin
            phase_in = phase_step;
            for (int i = 0; i < CH_LIMIT; i++) begin
               if (enabled_ff[i]) begin
                  // High wins over the wrap when the compare value is zero.
                  if (phase_wide == CMP_W'(compare_ff[i])) begin
                     high_in[i]  = 1'b1;
                     level_in[i] = 1'b1;
                  end else if (phase_step == '0) begin
                     low_in[i]   = 1'b1;
                     level_in[i] = 1'b0;
                  end
               end
            end
         end
         REQ_ALLOC: begin
            status_in = !found;
            if (found) begin
               chan_out_in = grant;
            end
            for (int i = 0; i < CH_LIMIT; i++) begin
               if (found && grant == CH_FIELD_W'(i)) begin
                  enabled_in[i] = 1'b1;
                  level_in[i]   = 1'b0;
                  compare_in[i] = req_rate_ff;
               end
            end
         end
         REQ_RECONF: begin
            status_in = 1'b1;
            for (int i = 0; i < CH_LIMIT; i++) begin
               if (req_channel_ff == CH_FIELD_W'(i) && enabled_ff[i]) begin
                  compare_in[i] = req_rate_ff;
                  status_in     = 1'b0;
               end
            end
         end
         REQ_CANCEL: begin
            for (int i = 0; i < CH_LIMIT; i++) begin
               if (req_channel_ff == CH_FIELD_W'(i)) begin
                  enabled_in[i] = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
      levels_in = MASK_W'(level_in);
   end

   assign rsp_status      = status_ff;
   assign rsp_channel_out = chan_out_ff;
   assign rsp_high_events = high_ff;
   assign rsp_low_events  = low_ff;
   assign rsp_levels      = levels_ff;

endmodule

`default_nettype wire
